[src/path_token_extractor_defines.svh]
// Assertion macros used by the checker file ptx_checker.sv.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef PATH_TOKEN_EXTRACTOR_DEFINES_SVH
`define PATH_TOKEN_EXTRACTOR_DEFINES_SVH

`define PTX_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

`define PTX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`define PTX_ASSERT_RESET(label, cons) \
  label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("reset check failed");

`endif

[src/ptx_pkg.sv]
`default_nettype none

package ptx_pkg;

  localparam int MAX_LINE_LENGTH = 4096;
  localparam int POS_W           = $clog2(MAX_LINE_LENGTH + 1);
  localparam int START_W         = $clog2(MAX_LINE_LENGTH);

  localparam int START_OUT_W = 12;
  localparam int LEN_OUT_W   = 13;
  localparam int START_SAT   = 4095;
  localparam int LEN_SAT     = 4096;

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_DASH       = 8'h2D;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
  localparam logic [7:0] CH_COLON      = 8'h3A;
  localparam logic [7:0] CH_DQUOTE     = 8'h22;
  localparam logic [7:0] CH_SQUOTE     = 8'h27;
  localparam logic [7:0] CH_SPACE      = 8'h20;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_ALPHA1 = 2'd1,
    MODE_UNQ    = 2'd2,
    MODE_QUOTED = 2'd3
  } ptx_mode_t;

  typedef struct packed {
    logic alpha;
    logic digit;
    logic sep;
    logic space;
    logic quote;
    logic single_q;
    logic colon;
    logic pathch;
  } ptx_class_t;

endpackage

`default_nettype wire

[src/ptx_classify.sv]
`default_nettype none

module ptx_classify
  import ptx_pkg::*;
(
  input  wire logic [7:0] ch,
  output ptx_class_t      cls
);

  always_comb begin
    cls.alpha    = (ch inside {[8'h61:8'h7A], [8'h41:8'h5A]});
    cls.digit    = (ch inside {[8'h30:8'h39]});
    cls.sep      = (ch == CH_SLASH) || (ch == CH_BACKSLASH);
    cls.space    = (ch == CH_SPACE) || (ch inside {[8'h09:8'h0D]});
    cls.quote    = (ch == CH_DQUOTE) || (ch == CH_SQUOTE);
    cls.single_q = (ch == CH_SQUOTE);
    cls.colon    = (ch == CH_COLON);
    cls.pathch   = cls.alpha || cls.digit || cls.sep ||
                   (ch == CH_UNDERSCORE) || (ch == CH_DASH) || (ch == CH_DOT);
  end

endmodule

`default_nettype wire

[src/path_token_extractor.sv]
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall   in_ch, in_last
// out      output     out_valid / out_stall out_path_start, out_path_length,
//                                           out_quoted, out_overflow
//
// Each byte is captured in the input register; the scan state and the result register are
// updated from it when it advances, and a stalled result can hold it there before that.
// A new byte may be accepted in every cycle.
// Reset is synchronous and returns the scanner to the between-tokens state.
// A stalled result holds the input register; further bytes are stalled only then.
`default_nettype none

module path_token_extractor
  import ptx_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [7:0]             in_ch,
  input  wire logic                   in_last,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [START_OUT_W-1:0]      out_path_start,
  output logic [LEN_OUT_W-1:0]        out_path_length,
  output logic                        out_quoted,
  output logic                        out_overflow
);

  localparam logic [POS_W-1:0]   MAX_POS  = POS_W'(MAX_LINE_LENGTH);
  localparam logic [POS_W-1:0]   LAST_POS = POS_W'(MAX_LINE_LENGTH - 1);
  localparam logic [START_W-1:0] LAST_OFF = START_W'(MAX_LINE_LENGTH - 1);

  logic                   in_v_r;
  logic [7:0]             ch_r;
  logic                   last_r;

  ptx_mode_t              mode_r, mode_nxt;
  logic                   qsingle_r, qsingle_nxt;
  logic [START_W-1:0]     tstart_r, tstart_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic                   qual_r, qual_nxt;
  logic                   ovf_r, ovf_nxt;

  logic                   out_v_r;
  logic [START_OUT_W-1:0] out_start_r;
  logic [LEN_OUT_W-1:0]   out_len_r;
  logic                   out_quoted_r;
  logic                   out_ovf_r;

  ptx_class_t             cls;
  logic                   advance;
  logic                   in_range;
  logic                   ovf_now;
  logic [START_W-1:0]     off;
  logic [POS_W-1:0]       pos_inc;
  logic [POS_W-1:0]       incl_end;
  logic [START_W-1:0]     qstart;
  logic                   close_q;
  logic                   emit;
  logic                   emit_incl;
  logic                   emit_quoted;
  logic [START_W-1:0]     emit_start;
  logic [POS_W-1:0]       emit_end;
  logic [POS_W-1:0]       start_ext;
  logic [POS_W-1:0]       len;
  logic [START_OUT_W-1:0] start_sat;
  logic [LEN_OUT_W-1:0]   len_sat;

  ptx_classify u_classify (
    .ch  (ch_r),
    .cls (cls)
  );

  assign advance  = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !advance;

  assign in_range = (pos_r < MAX_POS);
  assign ovf_now  = ovf_r || !in_range;
  assign off      = in_range ? pos_r[START_W-1:0] : LAST_OFF;
  assign pos_inc  = pos_r + POS_W'(1);
  assign incl_end = in_range ? pos_inc : MAX_POS;
  assign qstart   = (pos_inc > LAST_POS) ? LAST_OFF : pos_inc[START_W-1:0];
  assign close_q  = cls.quote && (cls.single_q == qsingle_r);

  always_comb begin
    mode_nxt = mode_r;
    case (mode_r)
      MODE_QUOTED: begin
        if (close_q) begin
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_ALPHA1, MODE_UNQ: begin
        if ((mode_r == MODE_ALPHA1) && cls.colon) begin
          mode_nxt = MODE_UNQ;
        end else if (cls.pathch) begin
          mode_nxt = MODE_UNQ;
        end else if (cls.quote) begin
          mode_nxt = MODE_QUOTED;
        end else begin
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_IDLE: begin
        if (cls.space) begin
          mode_nxt = MODE_IDLE;
        end else if (cls.quote) begin
          mode_nxt = MODE_QUOTED;
        end else if (cls.pathch) begin
          mode_nxt = cls.alpha ? MODE_ALPHA1 : MODE_UNQ;
        end
      end
      default: mode_nxt = MODE_IDLE;
    endcase
    if (last_r) begin
      mode_nxt = MODE_IDLE;
    end
  end

  always_comb begin
    qsingle_nxt = qsingle_r;
    tstart_nxt  = tstart_r;
    qual_nxt    = qual_r;
    emit        = 1'b0;
    emit_incl   = 1'b1;
    emit_quoted = 1'b0;
    emit_start  = tstart_r;
    case (mode_r)
      MODE_QUOTED: begin
        emit_quoted = 1'b1;
        if (close_q) begin
          emit      = qual_r;
          emit_incl = 1'b0;
        end else begin
          qual_nxt = qual_r || cls.sep;
          emit     = last_r && (qual_r || cls.sep);
        end
      end
      MODE_ALPHA1, MODE_UNQ: begin
        if ((mode_r == MODE_ALPHA1) && cls.colon) begin
          qual_nxt = 1'b1;
          emit     = last_r;
        end else if (cls.pathch) begin
          qual_nxt = qual_r || cls.sep;
          emit     = last_r && (qual_r || cls.sep);
        end else begin
          emit      = qual_r;
          emit_incl = 1'b0;
          qual_nxt  = 1'b0;
          if (cls.quote) begin
            qsingle_nxt = cls.single_q;
            tstart_nxt  = qstart;
          end
        end
      end
      MODE_IDLE: begin
        if (cls.space) begin
          emit = 1'b0;
        end else if (cls.quote) begin
          qsingle_nxt = cls.single_q;
          tstart_nxt  = qstart;
          qual_nxt    = 1'b0;
        end else if (cls.pathch) begin
          tstart_nxt = off;
          emit_start = off;
          qual_nxt   = cls.sep;
          emit       = last_r && cls.sep;
        end
      end
      default: emit = 1'b0;
    endcase
    pos_nxt = incl_end;
    ovf_nxt = ovf_now;
    if (last_r) begin
      qsingle_nxt = 1'b0;
      tstart_nxt  = '0;
      qual_nxt    = 1'b0;
      pos_nxt     = '0;
      ovf_nxt     = 1'b0;
    end
  end

  assign emit_end  = emit_incl ? incl_end : pos_r;
  assign start_ext = POS_W'(emit_start);
  assign len       = (emit_end > start_ext) ? (emit_end - start_ext) : POS_W'(1);
  assign start_sat = (32'(emit_start) > 32'(START_SAT)) ? START_OUT_W'(START_SAT)
                                                         : START_OUT_W'(emit_start);
  assign len_sat   = (32'(len) > 32'(LEN_SAT)) ? LEN_OUT_W'(LEN_SAT) : LEN_OUT_W'(len);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ch_r   <= in_ch;
      last_r <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      qsingle_r <= 1'b0;
      tstart_r  <= '0;
      pos_r     <= '0;
      qual_r    <= 1'b0;
      ovf_r     <= 1'b0;
    end else if (advance) begin
      mode_r    <= mode_nxt;
      qsingle_r <= qsingle_nxt;
      tstart_r  <= tstart_nxt;
      pos_r     <= pos_nxt;
      qual_r    <= qual_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= emit;
    end else if (out_v_r && !out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_start_r  <= start_sat;
      out_len_r    <= len_sat;
      out_quoted_r <= emit_quoted;
      out_ovf_r    <= ovf_now;
    end
  end

  assign out_valid       = out_v_r;
  assign out_path_start  = out_start_r;
  assign out_path_length = out_len_r;
  assign out_quoted      = out_quoted_r;
  assign out_overflow    = out_ovf_r;

endmodule

`default_nettype wire

[src/ptx_checker.sv]
`default_nettype none
`include "path_token_extractor_defines.svh"

module ptx_checker
  import ptx_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_stall,
  input wire logic [7:0]             in_ch,
  input wire logic                   in_last,
  input wire logic                   out_valid,
  input wire logic                   out_stall,
  input wire logic [START_OUT_W-1:0] out_path_start,
  input wire logic [LEN_OUT_W-1:0]   out_path_length,
  input wire logic                   out_quoted,
  input wire logic                   out_overflow
);

  logic [START_OUT_W+LEN_OUT_W+1:0] out_bus;

  assign out_bus = {out_path_start, out_path_length, out_quoted, out_overflow};

  // A stalled request stays offered with the same contents.
  `PTX_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_bus))

  // The input side only waits while a finished result is held back.
  `PTX_ASSERT_IMP(a_in_stall_cause, in_stall, out_valid && out_stall)

  // Every reported path holds at least one character.
  `PTX_ASSERT_IMP(a_len_nonzero, out_valid, out_path_length != '0)

  `PTX_ASSERT_RESET(a_reset_clear, !out_valid && !in_stall)

endmodule

bind path_token_extractor ptx_checker u_ptx_checker (.*);

`default_nettype wire

[tb/path_token_checker.sv]
`timescale 1ns / 100ps

module path_token_checker
  import ptx_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [7:0]             in_ch,
  input  logic                   in_last,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [START_OUT_W-1:0] out_path_start,
  input  logic [LEN_OUT_W-1:0]   out_path_length,
  input  logic                   out_quoted,
  input  logic                   out_overflow,
  output int                     mismatch_count,
  output int                     reports_pending
);

  typedef struct {
    logic [START_OUT_W-1:0] start;
    logic [LEN_OUT_W-1:0]   length;
    logic                   quoted;
    logic                   overflow;
  } path_report_t;

  path_report_t       reports_due[$];
  path_report_t       oldest;
  ptx_mode_t          mode;
  logic               single_quote;
  logic [START_W-1:0] tok_start;
  logic [POS_W-1:0]   line_pos;
  logic               tok_is_path;
  logic               line_long;

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_sep(logic [7:0] c);
    return c == CH_SLASH || c == CH_BACKSLASH;
  endfunction

  function automatic bit is_quote(logic [7:0] c);
    return c == CH_DQUOTE || c == CH_SQUOTE;
  endfunction

  function automatic bit is_path_char(logic [7:0] c);
    return is_letter(c) || (c >= "0" && c <= "9") || c == CH_UNDERSCORE || c == CH_DASH ||
           c == CH_DOT || is_sep(c);
  endfunction

  task automatic clear_line_state();
    mode         = MODE_IDLE;
    single_quote = 1'b0;
    tok_start    = '0;
    line_pos     = '0;
    tok_is_path  = 1'b0;
    line_long    = 1'b0;
  endtask

  task automatic push_report(int tok_end, bit quoted, bit overflow);
    path_report_t r;
    int           len;
    len = (tok_end > int'(tok_start)) ? tok_end - int'(tok_start) : 1;
    if (len > LEN_SAT) len = LEN_SAT;
    r.start    = tok_start;
    r.length   = len[LEN_OUT_W-1:0];
    r.quoted   = quoted;
    r.overflow = overflow;
    reports_due.insert(reports_due.size(), r);
  endtask

  task automatic open_quote(logic [7:0] c, int cnt);
    int s;
    s = (cnt + 1 > MAX_LINE_LENGTH - 1) ? MAX_LINE_LENGTH - 1 : cnt + 1;
    mode         = MODE_QUOTED;
    single_quote = (c == CH_SQUOTE);
    tok_start    = s[START_W-1:0];
    tok_is_path  = 1'b0;
  endtask

  task automatic scan_byte(logic [7:0] c, logic last);
    int         cnt;
    int         off;
    int         incl_end;
    bit         ovf;
    logic [7:0] closing;
    cnt      = int'(line_pos);
    ovf      = line_long || cnt >= MAX_LINE_LENGTH;
    off      = (cnt < MAX_LINE_LENGTH) ? cnt : MAX_LINE_LENGTH - 1;
    incl_end = (cnt < MAX_LINE_LENGTH) ? cnt + 1 : MAX_LINE_LENGTH;
    closing  = single_quote ? CH_SQUOTE : CH_DQUOTE;
    if (mode == MODE_QUOTED) begin
      if (c == closing) begin
        if (tok_is_path) push_report(cnt, 1'b1, ovf);
        mode = MODE_IDLE;
      end else begin
        if (is_sep(c)) tok_is_path = 1'b1;
        if (last && tok_is_path) push_report(incl_end, 1'b1, ovf);
      end
    end else if (mode == MODE_ALPHA1 && c == CH_COLON) begin
      tok_is_path = 1'b1;
      mode        = MODE_UNQ;
      if (last) push_report(incl_end, 1'b0, ovf);
    end else if (mode == MODE_ALPHA1 || mode == MODE_UNQ) begin
      if (is_path_char(c)) begin
        mode = MODE_UNQ;
        if (is_sep(c)) tok_is_path = 1'b1;
        if (last && tok_is_path) push_report(incl_end, 1'b0, ovf);
      end else begin
        if (tok_is_path) push_report(cnt, 1'b0, ovf);
        mode        = MODE_IDLE;
        tok_is_path = 1'b0;
        if (is_quote(c)) open_quote(c, cnt);
      end
    end else if (is_quote(c)) begin
      open_quote(c, cnt);
    end else if (is_path_char(c)) begin
      tok_start   = off[START_W-1:0];
      tok_is_path = is_sep(c);
      mode        = is_letter(c) ? MODE_ALPHA1 : MODE_UNQ;
      if (last && tok_is_path) push_report(incl_end, 1'b0, ovf);
    end
    line_pos  = incl_end[POS_W-1:0];
    line_long = ovf;
    if (last) clear_line_state();
  endtask

  initial begin
    mismatch_count  = 0;
    reports_pending = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_line_state();
      reports_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (reports_due.size() == 0) begin
          $error("path report with nothing pending: start %0d, length %0d",
                 out_path_start, out_path_length);
          mismatch_count++;
        end else begin
          oldest = reports_due.pop_front();
          if (out_path_start !== oldest.start) begin
            $error("path_start: expected %0d, got %0d", oldest.start, out_path_start);
            mismatch_count++;
          end
          if (out_path_length !== oldest.length) begin
            $error("path_length: expected %0d, got %0d", oldest.length, out_path_length);
            mismatch_count++;
          end
          if (out_quoted !== oldest.quoted) begin
            $error("quoted: expected %0b, got %0b", oldest.quoted, out_quoted);
            mismatch_count++;
          end
          if (out_overflow !== oldest.overflow) begin
            $error("overflow: expected %0b, got %0b", oldest.overflow, out_overflow);
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall) scan_byte(in_ch, in_last);
    end
    reports_pending = reports_due.size();
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
  import ptx_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [7:0]             in_ch;
  logic                   in_last;
  logic                   out_valid;
  logic                   out_stall;
  logic [START_OUT_W-1:0] out_path_start;
  logic [LEN_OUT_W-1:0]   out_path_length;
  logic                   out_quoted;
  logic                   out_overflow;
  int                     mismatch_count;
  int                     reports_pending;

  bit                     source_calm;
  bit                     sink_calm;
  logic [7:0]             line_bytes[$];
  int                     random_bytes;

  always #10 clk = ~clk;

  path_token_extractor u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_ch           (in_ch),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_path_start  (out_path_start),
    .out_path_length (out_path_length),
    .out_quoted      (out_quoted),
    .out_overflow    (out_overflow)
  );

  path_token_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_ch           (in_ch),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_path_start  (out_path_start),
    .out_path_length (out_path_length),
    .out_quoted      (out_quoted),
    .out_overflow    (out_overflow),
    .mismatch_count  (mismatch_count),
    .reports_pending (reports_pending)
  );

  function automatic logic [7:0] path_char();
    int k;
    k = $urandom_range(0, 11);
    if (k <= 5) return "a" + 8'($urandom_range(0, 25));
    if (k <= 7) return "A" + 8'($urandom_range(0, 25));
    if (k <= 9) return "0" + 8'($urandom_range(0, 9));
    k = $urandom_range(0, 2);
    return (k == 0) ? CH_UNDERSCORE : (k == 1) ? CH_DASH : CH_DOT;
  endfunction

  function automatic logic [7:0] sep_char();
    return $urandom_range(0, 1) ? CH_SLASH : CH_BACKSLASH;
  endfunction

  task automatic queue_byte(logic [7:0] c);
    line_bytes.insert(line_bytes.size(), c);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endtask

  task automatic add_blank();
    int k;
    repeat ($urandom_range(1, 2)) begin
      k = $urandom_range(0, 7);
      queue_byte((k >= 5) ? CH_SPACE : 8'h09 + 8'(k));
    end
  endtask

  task automatic add_path();
    int segs;
    if ($urandom_range(0, 3) == 0) begin
      queue_byte("A" + 8'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? 8'h20 : 8'h00));
      queue_byte(CH_COLON);
    end
    if ($urandom_range(0, 3) == 0) queue_byte(sep_char());
    segs = $urandom_range(1, 4);
    for (int s = 0; s < segs; s++) begin
      repeat ($urandom_range(1, 5)) queue_byte(path_char());
      if (s != segs - 1 || $urandom_range(0, 5) == 0) queue_byte(sep_char());
    end
  endtask

  task automatic add_quoted(bit closed);
    logic [7:0] q;
    int         k;
    q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
    queue_byte(q);
    repeat ($urandom_range(0, 8)) begin
      k = $urandom_range(0, 15);
      if (k <= 2) queue_byte(sep_char());
      else if (k == 3) queue_byte(CH_SPACE);
      else if (k == 4) queue_byte(8'($urandom_range(128, 255)));
      else if (k == 5) queue_byte((q == CH_SQUOTE) ? CH_DQUOTE : CH_SQUOTE);
      else if (k == 6) queue_byte(8'($urandom_range(0, 255)));
      else queue_byte(path_char());
    end
    if (closed) queue_byte(q);
  endtask

  task automatic make_line();
    int k;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) queue_byte(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 3) == 0) add_blank();
    repeat ($urandom_range(1, 6)) begin
      k = $urandom_range(0, 9);
      if (k <= 3) add_path();
      else if (k == 4) repeat ($urandom_range(1, 6)) queue_byte(path_char());
      else if (k <= 6) add_quoted(1'b1);
      else if (k == 7) repeat ($urandom_range(1, 3))
        queue_byte(8'($urandom_range(0, 255)));
      else if (k == 8) begin
        queue_byte("a" + 8'($urandom_range(0, 25)));
        queue_byte(CH_COLON);
      end else add_quoted(1'b0);
      if ($urandom_range(0, 4) != 0) add_blank();
    end
    if (line_bytes.size() == 0) queue_byte(path_char());
  endtask

  // The request is held, payload unchanged, until the block takes it.
  task automatic send_byte(logic [7:0] c, logic last);
    int gap;
    gap = source_calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_ch    <= c;
    in_last  <= last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_line();
    for (int i = 0; i < line_bytes.size(); i++)
      send_byte(line_bytes[i], i == line_bytes.size() - 1);
    line_bytes.delete();
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (reports_pending != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int hold;
    bit took;
    hold      = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      took = out_valid && !out_stall;
      @(negedge clk);
      if (took) begin
        hold = sink_calm ? 0 : $urandom_range(0, 10);
        if ($urandom_range(0, 15) == 0) sink_calm = !sink_calm;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_ch       = 8'h00;
    in_last     = 1'b0;
    source_calm = 1'b0;
    sink_calm   = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    add_text("C:");
    send_line();
    add_text("\"a/b\"");
    send_line();
    add_text("'x\\");
    send_line();
    add_text("\ta/b'c/");
    send_line();
    add_text("\"");
    send_line();
    line_bytes = '{CH_SLASH, 8'hFF, "z"};
    send_line();
    line_bytes = '{CH_SQUOTE, 8'hFF, CH_SLASH, CH_SQUOTE};
    send_line();
    drain();

    random_bytes = 0;
    while (random_bytes < 530) begin
      make_line();
      random_bytes += line_bytes.size();
      source_calm = ($urandom_range(0, 4) == 0);
      send_line();
      if ($urandom_range(0, 14) == 0) drain();
    end
    drain();

    if (reports_pending != 0) $error("%0d path reports never arrived", reports_pending);
    if (mismatch_count == 0 && reports_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
